[hw/rtl/bet_pkg.sv]
`default_nettype none

package bet_pkg;

  // field widths
  localparam int SAMPLE_BITS = 40;
  localparam int KIND_W      = 2;
  localparam int SR_W        = 18;
  localparam int BPH_W       = 17;
  localparam int CNT_W       = 32;
  localparam int ERR_W       = 32;

  localparam logic [KIND_W-1:0] KIND_A   = KIND_W'(1);
  localparam logic [SR_W-1:0]   SR_RESET = SR_W'(48000);

  localparam int SEC_PER_HOUR = 3600;
  localparam int US_PER_SEC   = 1000000;

  // datapath widths
  localparam int DEN_W   = 30;
  localparam int RB_W    = DEN_W + BPH_W;
  localparam int D_W     = BPH_W + SR_W;
  localparam int MAG_W   = DEN_W - 1;
  localparam int MUL_BW  = 20;
  localparam int US_W    = MAG_W + MUL_BW;
  localparam int MUL_AW  = (SAMPLE_BITS > DEN_W) ? SAMPLE_BITS : DEN_W;
  localparam int MUL_PW  = MUL_AW + MUL_BW;
  localparam int NSUM_W  = MUL_PW + 1;
  localparam int DIV_NW  = (SAMPLE_BITS > US_W + 2) ? SAMPLE_BITS : US_W + 2;
  localparam int DIV_DW  = D_W + 1;
  localparam int DIV_CW  = $clog2(DIV_NW + 1);

  localparam logic [CNT_W:0] CNT_MAX = {1'b0, {CNT_W{1'b1}}};

  // stream packing
  localparam int IN_OUTL_BIT = SAMPLE_BITS;
  localparam int IN_BPH_LSB  = SAMPLE_BITS + 1;
  localparam int IN_SYN_BIT  = IN_BPH_LSB + BPH_W;
  localparam int IN_PACK_W   = IN_SYN_BIT + 1;
  localparam int IN_TDATA_W  = ((IN_PACK_W + 7) / 8) * 8;

  localparam int OUT_PACK_W  = CNT_W + ERR_W + 2;
  localparam int OUT_TDATA_W = ((OUT_PACK_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    MUL_DEN,
    MUL_RB,
    MUL_MD,
    MUL_QB,
    MUL_D,
    MUL_US
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_QR,
    DIV_M,
    DIV_US
  } div_sel_e;

  typedef struct packed {
    logic     cap;
    logic     check;
    logic     lat_dt;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     lat_qr;
    logic     lat_m;
    logic     lat_mag;
    logic     ncheck;
    logic     lat_d;
    logic     load_out;
  } bet_cmd_t;

  typedef struct packed {
    logic go;
    logic div_done;
    logic newbeat;
    logic out_free;
  } bet_sts_t;

endpackage

`default_nettype wire

[hw/rtl/beat_error_tracker_core.sv]
// an ignored or an anchoring event frees the input after the capture and check states;
// a counted beat runs from input beat to result beat through three 51-step divisions
// on the one shared radix-2 divider and the control states around them; an A event that
// is no newer beat frees the input after the beat number check; events are taken only
// in idle, and the output register lets a result wait while the next event is taken
// reset (rst_ni low, async) drops the anchor and sets sample_rate_hz to 48000
`default_nettype none

module beat_error_tracker_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [bet_pkg::SR_W-1:0]           cfg_data_i,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // event_sample, outlier_in, beats_per_hour, synced_in
  input  wire  [bet_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // event_kind
  input  wire  [bet_pkg::KIND_W-1:0]         s_axis_tuser,
  input  wire                                s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // beat_index, timing_error_us, is_tac, outlier_out
  output logic [bet_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  bet_pkg::bet_cmd_t                 cmd;
  bet_pkg::bet_sts_t                 sts;
  logic [bet_pkg::CNT_W-1:0]         out_idx;
  logic signed [bet_pkg::ERR_W-1:0]  out_err;
  logic                              out_tac;
  logic                              out_outl;

  assign cfg_ready_o = 1'b1;

  bet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bet_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (s_axis_tuser),
    .smp_i       (s_axis_tdata[bet_pkg::SAMPLE_BITS-1:0]),
    .outl_i      (s_axis_tdata[bet_pkg::IN_OUTL_BIT]),
    .bph_i       (s_axis_tdata[bet_pkg::IN_BPH_LSB +: bet_pkg::BPH_W]),
    .syn_i       (s_axis_tdata[bet_pkg::IN_SYN_BIT]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_idx_o   (out_idx),
    .out_err_o   (out_err),
    .out_tac_o   (out_tac),
    .out_outl_o  (out_outl)
  );

  assign m_axis_tdata = bet_pkg::OUT_TDATA_W'({out_outl, out_tac, out_err, out_idx});

endmodule

`default_nettype wire

[hw/rtl/bet_div.sv]
`default_nettype none

module bet_div (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [bet_pkg::DIV_NW-1:0]     dividend_i,
  input  wire  [bet_pkg::DIV_DW-1:0]     divisor_i,
  output logic                           done_o,
  output logic [bet_pkg::DIV_NW-1:0]     quot_o,
  output logic [bet_pkg::DIV_DW-1:0]     rem_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [bet_pkg::DIV_CW-1:0]    cnt_q;
  logic [bet_pkg::DIV_NW-1:0]    quo_q, quo_d;
  logic [bet_pkg::DIV_DW-1:0]    rem_q, rem_d;
  logic [bet_pkg::DIV_DW-1:0]    dvs_q;
  logic [bet_pkg::DIV_DW:0]      sh;
  logic [bet_pkg::DIV_DW:0]      diff;
  logic                          ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    sh    = {rem_q, quo_q[bet_pkg::DIV_NW-1]};
    diff  = sh - {1'b0, dvs_q};
    ge    = (sh >= {1'b0, dvs_q});
    rem_d = ge ? diff[bet_pkg::DIV_DW-1:0] : sh[bet_pkg::DIV_DW-1:0];
    quo_d = {quo_q[bet_pkg::DIV_NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= bet_pkg::DIV_CW'(bet_pkg::DIV_NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - bet_pkg::DIV_CW'(1);
      if (cnt_q == bet_pkg::DIV_CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[hw/rtl/bet_ctrl.sv]
`default_nettype none

module bet_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  bet_pkg::bet_sts_t  sts_i,
  output bet_pkg::bet_cmd_t  cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_CHECK = 15'h0002,
    S_DEN   = 15'h0004,
    S_DIV1S = 15'h0008,
    S_DIV1W = 15'h0010,
    S_RB    = 15'h0020,
    S_DIV2S = 15'h0040,
    S_DIV2W = 15'h0080,
    S_MD    = 15'h0100,
    S_MAG   = 15'h0200,
    S_NCHK  = 15'h0400,
    S_US    = 15'h0800,
    S_DIV3S = 15'h1000,
    S_DIV3W = 15'h2000,
    S_OUT   = 15'h4000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.go ? S_DEN : S_IDLE;
      end
      S_DEN: begin
        cmd_o.lat_dt  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bet_pkg::MUL_DEN;
        state_d       = S_DIV1S;
      end
      S_DIV1S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = bet_pkg::DIV_QR;
        state_d         = S_DIV1W;
      end
      S_DIV1W: begin
        if (sts_i.div_done) begin
          cmd_o.lat_qr = 1'b1;
          state_d      = S_RB;
        end
      end
      S_RB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bet_pkg::MUL_RB;
        state_d       = S_DIV2S;
      end
      S_DIV2S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = bet_pkg::DIV_M;
        state_d         = S_DIV2W;
      end
      S_DIV2W: begin
        if (sts_i.div_done) begin
          cmd_o.lat_m = 1'b1;
          state_d     = S_MD;
        end
      end
      S_MD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bet_pkg::MUL_MD;
        state_d       = S_MAG;
      end
      S_MAG: begin
        cmd_o.lat_mag = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bet_pkg::MUL_QB;
        state_d       = S_NCHK;
      end
      S_NCHK: begin
        cmd_o.ncheck  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bet_pkg::MUL_D;
        state_d       = sts_i.newbeat ? S_US : S_IDLE;
      end
      S_US: begin
        cmd_o.lat_d   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bet_pkg::MUL_US;
        state_d       = S_DIV3S;
      end
      S_DIV3S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = bet_pkg::DIV_US;
        state_d         = S_DIV3W;
      end
      S_DIV3W: begin
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bet_dp.sv]
`default_nettype none

module bet_dp (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  bet_pkg::bet_cmd_t                     cmd_i,
  output bet_pkg::bet_sts_t                     sts_o,
  input  wire                                   cfg_we_i,
  input  wire  [bet_pkg::SR_W-1:0]              cfg_data_i,
  input  wire  [bet_pkg::KIND_W-1:0]            kind_i,
  input  wire  [bet_pkg::SAMPLE_BITS-1:0]       smp_i,
  input  wire                                   outl_i,
  input  wire  [bet_pkg::BPH_W-1:0]             bph_i,
  input  wire                                   syn_i,
  input  wire                                   out_ready_i,
  output logic                                  out_valid_o,
  output logic [bet_pkg::CNT_W-1:0]             out_idx_o,
  output logic signed [bet_pkg::ERR_W-1:0]      out_err_o,
  output logic                                  out_tac_o,
  output logic                                  out_outl_o
);

  logic [bet_pkg::SR_W-1:0]         sr_q;

  logic [bet_pkg::KIND_W-1:0]       it_kind_q;
  logic [bet_pkg::SAMPLE_BITS-1:0]  it_smp_q;
  logic                             it_outl_q;
  logic [bet_pkg::BPH_W-1:0]        it_bph_q;
  logic                             it_syn_q;

  logic                             anchored_q;
  logic [bet_pkg::SAMPLE_BITS-1:0]  anchor_q;
  logic [bet_pkg::SAMPLE_BITS-1:0]  last_a_q;
  logic [bet_pkg::CNT_W-1:0]        beat_count_q;
  logic [bet_pkg::BPH_W-1:0]        anchor_rate_q;
  logic                             out_valid_q;

  logic [bet_pkg::SAMPLE_BITS-1:0]  dt_q;
  logic [bet_pkg::DEN_W-1:0]        den_q;
  logic [bet_pkg::SAMPLE_BITS-1:0]  q_q;
  logic [bet_pkg::DEN_W-1:0]        r_q;
  logic [bet_pkg::RB_W-1:0]         rb_q;
  logic [bet_pkg::BPH_W-1:0]        m_q;
  logic [bet_pkg::MAG_W-1:0]        mag_q;
  logic                             neg_q;
  logic [bet_pkg::CNT_W-1:0]        n_q;
  logic [bet_pkg::D_W-1:0]          d_q;
  logic [bet_pkg::MUL_PW-1:0]       mul_q;

  logic [bet_pkg::MUL_AW-1:0]       mul_a;
  logic [bet_pkg::MUL_BW-1:0]       mul_b;
  logic [bet_pkg::DIV_NW-1:0]       div_n;
  logic [bet_pkg::DIV_DW-1:0]       div_d;
  logic                             div_done;
  logic [bet_pkg::DIV_NW-1:0]       div_quot;
  logic [bet_pkg::DIV_DW-1:0]       div_rem;

  logic                             ign, drop, anch_eff, is_a, older;
  logic [bet_pkg::RB_W-1:0]         md_v, mag_diff;
  logic [bet_pkg::NSUM_W-1:0]       n_full;
  logic                             q_big, newbeat;
  logic [bet_pkg::ERR_W-1:0]        err_mag;

  // event screening
  always_comb begin
    ign      = (sr_q == '0) || !it_syn_q || (it_bph_q == '0);
    drop     = anchored_q && (it_bph_q != anchor_rate_q);
    anch_eff = anchored_q && !drop;
    is_a     = (it_kind_q == bet_pkg::KIND_A);
    older    = anch_eff && (it_smp_q <= last_a_q);
  end

  // beat number check
  always_comb begin
    n_full  = bet_pkg::NSUM_W'(mul_q) + bet_pkg::NSUM_W'(m_q);
    q_big   = bet_pkg::MUL_PW'(q_q) > bet_pkg::MUL_PW'(bet_pkg::CNT_MAX);
    newbeat = !q_big && (n_full <= bet_pkg::NSUM_W'(bet_pkg::CNT_MAX))
              && (n_full[bet_pkg::CNT_W-1:0] > beat_count_q);
  end

  always_comb begin
    md_v     = mul_q[bet_pkg::RB_W-1:0];
    mag_diff = (rb_q >= md_v) ? (rb_q - md_v) : (md_v - rb_q);
    err_mag  = div_quot[bet_pkg::ERR_W-1:0];
  end

  always_comb begin
    sts_o.go       = !ign && is_a && anch_eff && !older;
    sts_o.div_done = div_done;
    sts_o.newbeat  = newbeat;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      bet_pkg::MUL_DEN: begin
        mul_a = bet_pkg::MUL_AW'(sr_q);
        mul_b = bet_pkg::MUL_BW'(bet_pkg::SEC_PER_HOUR);
      end
      bet_pkg::MUL_RB: begin
        mul_a = bet_pkg::MUL_AW'(r_q);
        mul_b = bet_pkg::MUL_BW'(it_bph_q);
      end
      bet_pkg::MUL_MD: begin
        mul_a = bet_pkg::MUL_AW'(den_q);
        mul_b = bet_pkg::MUL_BW'(m_q);
      end
      bet_pkg::MUL_QB: begin
        mul_a = bet_pkg::MUL_AW'(q_q);
        mul_b = bet_pkg::MUL_BW'(it_bph_q);
      end
      bet_pkg::MUL_D: begin
        mul_a = bet_pkg::MUL_AW'(sr_q);
        mul_b = bet_pkg::MUL_BW'(it_bph_q);
      end
      bet_pkg::MUL_US: begin
        mul_a = bet_pkg::MUL_AW'(mag_q);
        mul_b = bet_pkg::MUL_BW'(bet_pkg::US_PER_SEC);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shared divider operands, rounding terms folded into the dividend of the m and us divisions
  always_comb begin
    case (cmd_i.div_sel)
      bet_pkg::DIV_QR: begin
        div_n = bet_pkg::DIV_NW'(dt_q);
        div_d = bet_pkg::DIV_DW'(mul_q[bet_pkg::DEN_W-1:0]);
      end
      bet_pkg::DIV_M: begin
        div_n = bet_pkg::DIV_NW'({mul_q[bet_pkg::RB_W-1:0], 1'b0})
                + bet_pkg::DIV_NW'(den_q);
        div_d = bet_pkg::DIV_DW'({den_q, 1'b0});
      end
      bet_pkg::DIV_US: begin
        div_n = bet_pkg::DIV_NW'({mul_q[bet_pkg::US_W-1:0], 1'b0})
                + bet_pkg::DIV_NW'(d_q);
        div_d = bet_pkg::DIV_DW'({d_q, 1'b0});
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  bet_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q          <= bet_pkg::SR_RESET;
      anchored_q    <= 1'b0;
      anchor_q      <= '0;
      last_a_q      <= '0;
      beat_count_q  <= '0;
      anchor_rate_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sr_q <= cfg_data_i;
      end
      if (cmd_i.check && !ign) begin
        if (drop) begin
          anchored_q <= 1'b0;
        end
        if (is_a && !older) begin
          last_a_q <= it_smp_q;
          if (!anch_eff) begin
            anchored_q    <= 1'b1;
            anchor_q      <= it_smp_q;
            beat_count_q  <= '0;
            anchor_rate_q <= it_bph_q;
          end
        end
      end
      if (cmd_i.ncheck && newbeat) begin
        beat_count_q <= n_full[bet_pkg::CNT_W-1:0];
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      it_kind_q <= kind_i;
      it_smp_q  <= smp_i;
      it_outl_q <= outl_i;
      it_bph_q  <= bph_i;
      it_syn_q  <= syn_i;
    end
    if (cmd_i.lat_dt) begin
      dt_q <= it_smp_q - anchor_q;
    end
    if (cmd_i.mul_en) begin
      mul_q <= bet_pkg::MUL_PW'(mul_a) * bet_pkg::MUL_PW'(mul_b);
    end
    if (cmd_i.div_start && (cmd_i.div_sel == bet_pkg::DIV_QR)) begin
      den_q <= mul_q[bet_pkg::DEN_W-1:0];
    end
    if (cmd_i.div_start && (cmd_i.div_sel == bet_pkg::DIV_M)) begin
      rb_q <= mul_q[bet_pkg::RB_W-1:0];
    end
    if (cmd_i.lat_qr) begin
      q_q <= div_quot[bet_pkg::SAMPLE_BITS-1:0];
      r_q <= div_rem[bet_pkg::DEN_W-1:0];
    end
    if (cmd_i.lat_m) begin
      m_q <= div_quot[bet_pkg::BPH_W-1:0];
    end
    if (cmd_i.lat_mag) begin
      neg_q <= (rb_q >= md_v);
      mag_q <= mag_diff[bet_pkg::MAG_W-1:0];
    end
    if (cmd_i.ncheck) begin
      n_q <= n_full[bet_pkg::CNT_W-1:0];
    end
    if (cmd_i.lat_d) begin
      d_q <= mul_q[bet_pkg::D_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_idx_o  <= n_q;
      out_err_o  <= neg_q ? (bet_pkg::ERR_W'(0) - err_mag) : err_mag;
      out_tac_o  <= n_q[0];
      out_outl_o <= it_outl_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/bet_chk.sv]
`default_nettype none

module bet_chk (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire [bet_pkg::KIND_W-1:0]         s_axis_tuser,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [bet_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

  // one event at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an event is in work");

  // a new result only comes out of a busy block
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work");

  // non-A events are dropped quickly
  a_skip_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != bet_pkg::KIND_A))
    |-> ##2 s_axis_tready)
    else $error("ignored event kept the block busy");

endmodule

bind beat_error_tracker_core bet_chk u_chk (.*);

`default_nettype wire

[tb/beat_error_tracker_core_tb.sv]
`timescale 1ns / 1ps

module beat_error_tracker_core_tb;
  import bet_pkg::*;

  localparam int          LIMIT_CYCLES  = 2_000_000;
  localparam int          SETTLE_CYCLES = 400;
  localparam int          HOLD_CYCLES   = 4000;
  localparam int          PHASE_ITEMS   = 195;
  localparam logic [63:0] SAMPLE_SPAN   = 64'd1 << SAMPLE_BITS;

  localparam logic [KIND_W-1:0] KIND_NONE = KIND_A - KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_B    = KIND_A + KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_C    = KIND_A + KIND_W'(2);

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [SAMPLE_BITS-1:0] smp;
    logic                   outl;
    logic [BPH_W-1:0]       bph;
    logic                   syn;
    logic                   last;
  } evt_t;

  // beat_index in the lowest bits
  typedef struct packed {
    logic             outl;
    logic             tac;
    logic [ERR_W-1:0] err;
    logic [CNT_W-1:0] idx;
  } beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [SR_W-1:0]        cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // event_sample, outlier_in, beats_per_hour, synced_in
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // event_kind
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // beat_index, timing_error_us, is_tac, outlier_out
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // tracker state as the block should hold it
  logic [SR_W-1:0]        rate_hz;
  logic                   anch_on;
  logic [SAMPLE_BITS-1:0] anch_smp;
  logic [SAMPLE_BITS-1:0] last_smp;
  logic [CNT_W-1:0]       beat_cnt;
  logic [BPH_W-1:0]       anch_bph;

  beat_t    beats_due[$];
  int       err_cnt;
  int       cycles;
  int       burst_left;
  int       items_sent;
  bit       hold_req;
  int       hold_left;
  int       rx_left;
  rx_mode_e rx_mode;

  beat_error_tracker_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic evt_t mk_evt(input logic [KIND_W-1:0] kind,
                                  input logic [SAMPLE_BITS-1:0] smp,
                                  input logic [BPH_W-1:0] bph,
                                  input logic syn, input logic outl);
    evt_t ev;
    ev.kind = kind;
    ev.smp  = smp;
    ev.bph  = bph;
    ev.syn  = syn;
    ev.outl = outl;
    ev.last = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // rounded beat number and negated timing error of one event
  task automatic track_event(input evt_t ev);
    logic [SAMPLE_BITS-1:0] dt40;
    logic [63:0]            den, dt, q, r, rb, m, md, n, mag, d;
    beat_t                  res;
    if (rate_hz == 0 || !ev.syn || ev.bph == 0) return;
    if (anch_on && ev.bph != anch_bph) anch_on = 1'b0;
    if (ev.kind != KIND_A) return;
    if (anch_on && ev.smp <= last_smp) return;
    if (!anch_on) begin
      anch_smp = ev.smp;
      last_smp = ev.smp;
      beat_cnt = '0;
      anch_bph = ev.bph;
      anch_on  = 1'b1;
      return;
    end
    den  = 64'(SEC_PER_HOUR) * 64'(rate_hz);
    dt40 = ev.smp - anch_smp;
    dt   = 64'(dt40);
    q    = dt / den;
    r    = dt % den;
    rb   = r * 64'(ev.bph);
    m    = (64'd2 * rb + den) / (64'd2 * den);
    md   = m * den;
    last_smp = ev.smp;
    if (q > 64'hFFFF_FFFF) return;
    n = q * 64'(ev.bph) + m;
    if (n > 64'hFFFF_FFFF || n <= 64'(beat_cnt)) return;
    beat_cnt = n[CNT_W-1:0];
    d = 64'(ev.bph) * 64'(rate_hz);
    if (rb >= md) begin
      mag     = (64'd2 * (rb - md) * 64'(US_PER_SEC) + d) / (64'd2 * d);
      res.err = -mag[ERR_W-1:0];
    end else begin
      mag     = (64'd2 * (md - rb) * 64'(US_PER_SEC) + d) / (64'd2 * d);
      res.err = mag[ERR_W-1:0];
    end
    res.idx  = n[CNT_W-1:0];
    res.tac  = n[0];
    res.outl = ev.outl;
    beats_due.insert(beats_due.size(), res);
  endtask

  task automatic offer_event(input evt_t ev);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({ev.syn, ev.bph, ev.outl, ev.smp});
    s_axis_tuser  <= ev.kind;
    s_axis_tlast  <= ev.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_event(ev);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [SR_W-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    rate_hz = value;
  endtask

  function automatic logic [BPH_W-1:0] pick_bph();
    case ($urandom_range(0, 11))
      0: return BPH_W'(18000);
      1: return BPH_W'(21600);
      2: return BPH_W'(28800);
      3: return BPH_W'(36000);
      4: return BPH_W'(72000);
      5: return BPH_W'($urandom_range(1, 40));
      default: return BPH_W'($urandom_range(1, 72000));
    endcase
  endfunction

  // events that the tracker drops or that break the running anchor
  task automatic offer_noise(input logic [BPH_W-1:0] bph, input logic [SAMPLE_BITS-1:0] smp);
    logic [KIND_W-1:0] kind;
    kind = KIND_W'($urandom_range(0, 3));
    if (kind == KIND_A) kind = KIND_B;
    case ($urandom_range(0, 9))
      0, 1:    offer_event(mk_evt(KIND_A, smp, bph, 1'b0, 1'($urandom_range(0, 1))));
      2, 3:    offer_event(mk_evt(KIND_A, smp, '0, 1'b1, 1'($urandom_range(0, 1))));
      4:       offer_event(mk_evt(KIND_W'($urandom_range(0, 3)), smp, pick_bph(), 1'b1,
                                  1'($urandom_range(0, 1))));
      default: offer_event(mk_evt(kind, smp, bph, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
    endcase
  endtask

  // one anchor followed by jittered, mostly consecutive beats
  task automatic run_track(input int beats, input int noise_pct);
    logic [BPH_W-1:0]       bph;
    logic [63:0]            ivl, span, room, base, k, off, lim, jmag;
    logic [SAMPLE_BITS-1:0] smp, prev;
    int                     i, step, jmode;
    bph  = pick_bph();
    ivl  = (64'd3600 * 64'(rate_hz)) / 64'(bph);
    span = ivl * 64'(2 * beats + 4) + 64'd8;
    room = SAMPLE_SPAN - span;
    if ($urandom_range(0, 11) == 0) base = SAMPLE_SPAN - span / 2;
    else base = {$urandom, $urandom} % room;
    prev = base[SAMPLE_BITS-1:0];
    offer_event(mk_evt(KIND_A, prev, bph, 1'b1, 1'($urandom_range(0, 1))));
    items_sent++;
    k = 0;
    for (i = 1; i < beats; i++) begin
      if ($urandom_range(0, 99) < noise_pct) offer_noise(bph, SAMPLE_BITS'({$urandom, $urandom}));
      step = $urandom_range(0, 19);
      k += (step == 0) ? 0 : ((step < 17) ? 1 : step - 15);
      off   = (k * 64'd3600 * 64'(rate_hz) + 64'(bph) / 2) / 64'(bph);
      jmode = $urandom_range(0, 9);
      lim   = (jmode < 6) ? ivl / 16 : ((jmode < 9) ? ivl / 2 : 64'd0);
      jmag  = 64'($urandom_range(0, 32'(lim)));
      if ($urandom_range(0, 1) == 0) smp = SAMPLE_BITS'(base + off + jmag);
      else smp = SAMPLE_BITS'(base + off - jmag);
      if ($urandom_range(0, 29) == 0) smp = prev - SAMPLE_BITS'($urandom_range(0, 3));
      offer_event(mk_evt(KIND_A, smp, bph, 1'b1, 1'($urandom_range(0, 1))));
      items_sent++;
      prev = smp;
    end
  endtask

  task automatic test_directed();
    offer_event(mk_evt(KIND_A, 40'd0, 17'd21600, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_NONE, 40'd8000, 17'd21600, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_B, 40'd8000, 17'd21600, 1'b1, 1'b1));
    offer_event(mk_evt(KIND_C, 40'd8000, 17'd21600, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd8000, 17'd21600, 1'b0, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd8000, 17'd0, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd8100, 17'd21600, 1'b1, 1'b1));
    offer_event(mk_evt(KIND_A, 40'd8100, 17'd21600, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd8200, 17'd21600, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd15963, 17'd21600, 1'b1, 1'b0));
    // exactly half way between beats
    offer_event(mk_evt(KIND_A, 40'd44000, 17'd21600, 1'b1, 1'b1));
    offer_event(mk_evt(KIND_NONE, 40'd45000, 17'd28800, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd50000, 17'd28800, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd56000, 17'd28800, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, {SAMPLE_BITS{1'b1}} - 40'd4800, 17'd72000, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, {SAMPLE_BITS{1'b1}}, 17'd72000, 1'b1, 1'b1));
    offer_event(mk_evt(KIND_A, 40'd0, 17'd72000, 1'b1, 1'b0));
    // slowest rate, largest errors of both signs
    offer_event(mk_evt(KIND_A, 40'd1000, 17'd1, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd86401000, 17'd1, 1'b1, 1'b1));
    offer_event(mk_evt(KIND_A, 40'd432000999, 17'd1, 1'b1, 1'b0));
    settle();
  endtask

  task automatic test_rate_extremes();
    write_rate(SR_W'(1000));
    offer_event(mk_evt(KIND_A, 40'd0, 17'd72000, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd100, 17'd72000, 1'b1, 1'b1));
    // beat number past 32 bits
    offer_event(mk_evt(KIND_A, 40'd214748365825, 17'd72000, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd214748369800, 17'd72000, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd257698037760, 17'd36000, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd257698037960, 17'd36000, 1'b1, 1'b1));
    write_rate('0);
    offer_event(mk_evt(KIND_A, 40'd257698038060, 17'd36000, 1'b1, 1'b0));
    offer_event(mk_evt(KIND_A, 40'd257698038260, 17'd18000, 1'b1, 1'b0));
    settle();
  endtask

  task automatic test_random_tracks(input logic [SR_W-1:0] rate, input int n_items);
    int goal;
    write_rate(rate);
    goal = items_sent + n_items;
    while (items_sent < goal) run_track($urandom_range(8, 40), 15);
  endtask

  task automatic test_output_hold();
    settle();
    hold_req = 1'b1;
    run_track(30, 0);
    settle();
  endtask

  // receiver stall pattern and the long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default:   m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_beats
    beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = beat_t'(m_axis_tdata[OUT_PACK_W-1:0]);
      if (beats_due.size() == 0) begin
        $error("unexpected beat: beat_index %0d timing_error_us %0d", got.idx,
               $signed(got.err));
        err_cnt++;
      end else begin
        want = beats_due.pop_front();
        if (got.idx !== want.idx) begin
          $error("beat_index: expected %0d, actual %0d", want.idx, got.idx);
          err_cnt++;
        end
        if (got.err !== want.err) begin
          $error("timing_error_us: expected %0d, actual %0d", $signed(want.err),
                 $signed(got.err));
          err_cnt++;
        end
        if (got.tac !== want.tac) begin
          $error("is_tac: expected %0d, actual %0d", want.tac, got.tac);
          err_cnt++;
        end
        if (got.outl !== want.outl) begin
          $error("outlier_out: expected %0d, actual %0d", want.outl, got.outl);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    rate_hz    = SR_RESET;
    anch_on    = 1'b0;
    anch_smp   = '0;
    last_smp   = '0;
    beat_cnt   = '0;
    anch_bph   = '0;
    err_cnt    = 0;
    cycles     = 0;
    burst_left = 0;
    items_sent = 0;
    hold_req   = 1'b0;
    hold_left  = 0;
    rx_left    = 0;
    rx_mode    = RX_OPEN;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_rate_extremes();
    test_random_tracks(SR_W'(8000), PHASE_ITEMS);
    test_output_hold();
    test_random_tracks(SR_W'(192000), PHASE_ITEMS);
    test_random_tracks(SR_W'(44100), PHASE_ITEMS);
    test_random_tracks(SR_W'($urandom_range(8000, 192000)), PHASE_ITEMS);
    test_random_tracks(SR_W'(48000), PHASE_ITEMS);
    settle();

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/bet_pkg.sv
hw/rtl/bet_div.sv
hw/rtl/bet_ctrl.sv
hw/rtl/bet_dp.sv
hw/rtl/beat_error_tracker_core.sv
hw/rtl/bet_chk.sv
tb/beat_error_tracker_core_tb.sv
